### hdl/aimd_pkg.sv
// Shared types and constants for the AIMD congestion-window controller.
// Used by aimd_iter_unit and aimd_window_controller_core; depends on nothing.

package aimd_pkg;

    localparam int unsigned WIN_W   = 32;
    localparam int unsigned CNT_W   = 16;
    localparam int unsigned STEP_W  = 6;
    localparam int unsigned RES_W   = WIN_W + 1;

    localparam logic [1:0] FUNC_INTEREST = 2'd0;
    localparam logic [1:0] FUNC_DATA     = 2'd1;
    localparam logic [1:0] FUNC_TIMEOUT  = 2'd2;

    localparam logic [1:0] SEND_RETRY = 2'd0;
    localparam logic [1:0] SEND_FULL  = 2'd1;
    localparam logic [1:0] SEND_OK    = 2'd2;

    localparam logic [1:0] CFG_DECREASE = 2'd0;
    localparam logic [1:0] CFG_REACT    = 2'd1;
    localparam logic [1:0] CFG_INIT_WIN = 2'd2;

    localparam logic [WIN_W-1:0] WIN_MAX   = '1;
    localparam logic [CNT_W-1:0] COUNT_MAX = '1;
    localparam logic [RES_W-1:0] ONE_FIXED = RES_W'(65536);

    localparam logic [STEP_W-1:0] ADD_STEPS = STEP_W'(1);
    localparam logic [STEP_W-1:0] MUL_STEPS = STEP_W'(16);
    localparam logic [STEP_W-1:0] DIV_STEPS = STEP_W'(33);

    typedef enum logic [1:0] {
        OP_ADD,
        OP_MUL,
        OP_DIV
    } unit_op_t;

    typedef struct packed {
        logic     start;
        unit_op_t op;
    } unit_cmd_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [RES_W-1:0] result;
    } unit_status_t;

endpackage

### hdl/aimd_iter_unit.sv
// Iterative arithmetic unit: one shared 33-bit adder/subtractor that performs a
// single add, a 32x16 shift-add multiply or a 2^32 / divisor restoring division.
// Depends on aimd_pkg.

module aimd_iter_unit
    import aimd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  unit_cmd_t          cmd,
    input  logic [WIN_W-1:0]   opa,
    input  logic [RES_W-1:0]   opb,
    output unit_status_t       status
);

    unit_op_t          op_reg;
    logic [WIN_W-1:0]  opa_reg;
    logic [RES_W-1:0]  opb_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic              done_reg;
    logic [RES_W-1:0]  rem_reg;
    logic [RES_W-1:0]  quo_reg;

    logic [RES_W-1:0]  add_a;
    logic [RES_W-1:0]  add_b;
    logic              add_sub;
    logic [RES_W:0]    sum;
    logic [RES_W-1:0]  shifted;
    logic              ge;

    assign shifted = {rem_reg[WIN_W-1:0], quo_reg[RES_W-1]};

    always_comb
    begin
        add_a   = {1'b0, opa_reg};
        add_b   = opb_reg;
        add_sub = 1'b0;
        case (op_reg)
            OP_DIV:
            begin
                add_a   = shifted;
                add_b   = {1'b0, opa_reg};
                add_sub = 1'b1;
            end
            OP_MUL:
            begin
                add_a = {1'b0, rem_reg[WIN_W-1:0]};
                add_b = quo_reg[0] ? {1'b0, opa_reg} : '0;
            end
            default:
            begin
                add_a = {1'b0, opa_reg};
                add_b = opb_reg;
            end
        endcase
    end

    // With the subtract flag set, the carry out of the top bit means a >= b.
    assign sum = {1'b0, add_a} + {1'b0, add_sub ? ~add_b : add_b}
               + {{RES_W{1'b0}}, add_sub};
    assign ge  = sum[RES_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg   <= OP_ADD;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cnt_reg == ADD_STEPS);
            if (cmd.start)
            begin
                op_reg <= cmd.op;
                unique case (cmd.op)
                    OP_DIV:  cnt_reg <= DIV_STEPS;
                    OP_MUL:  cnt_reg <= MUL_STEPS;
                    default: cnt_reg <= ADD_STEPS;
                endcase
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - STEP_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            opa_reg <= opa;
            opb_reg <= opb;
            rem_reg <= '0;
            unique case (cmd.op)
                OP_DIV:  quo_reg <= {1'b1, {WIN_W{1'b0}}};
                OP_MUL:  quo_reg <= {{(RES_W-16){1'b0}}, opb[15:0]};
                default: quo_reg <= '0;
            endcase
        end
        else if (cnt_reg != '0)
        begin
            case (op_reg)
                OP_DIV:
                begin
                    rem_reg <= ge ? sum[RES_W-1:0] : shifted;
                    quo_reg <= {quo_reg[WIN_W-1:0], ge};
                end
                OP_MUL:
                begin
                    // Partial product moves right; its low bit drops into the multiplier slot.
                    rem_reg        <= {1'b0, sum[RES_W-1:1]};
                    quo_reg[15:0]  <= {sum[0], quo_reg[15:1]};
                end
                default:
                begin
                    rem_reg <= sum[RES_W-1:0];
                end
            endcase
        end
    end

    assign status.busy   = (cnt_reg != '0);
    assign status.done   = done_reg;
    assign status.result = (op_reg == OP_DIV) ? quo_reg : rem_reg;

endmodule

### hdl/aimd_window_controller_core.sv
// Top level of the AIMD congestion-window controller: event decode, window and
// threshold state, configuration registers and the registered result stage.
// Depends on aimd_pkg and aimd_iter_unit.
//
//  Channel | Signals                          | Contents (lowest bit first)
//  --------+----------------------------------+------------------------------------
//  input   | s_tvalid s_tready s_tdata s_tuser| tdata: func[1:0]; tuser: congestion_mark
//  output  | m_tvalid m_tready m_tdata        | send_state[1:0], window[33:2], in_flight[49:34]
//  config  | cfg_wr_en cfg_index cfg_wdata    | 0 decrease_factor, 1 react_to_marks, 2 initial_window
//
// An interest, ignored mark or unknown event goes straight to the result stage;
// slow-start growth takes one add; a decrease takes the 16-step shift-add multiply;
// growth in congestion avoidance takes the 33-step restoring division, then an add.
// The input is ready only while no event is in progress. A finished result waits in
// the output register, and the next event is taken while it waits.
// Reset is asynchronous and active low; it loads the default registers and state.

module aimd_window_controller_core
    import aimd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // func[1:0], zero fill above
    input  logic        s_tuser,    // congestion_mark
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,    // send_state[1:0], window[33:2], in_flight[49:34]
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_WAIT_DIV,
        S_WAIT_ADD,
        S_WAIT_MUL,
        S_OUT
    } state_t;

    state_t            state_reg;
    logic [15:0]       beta_reg;
    logic              react_reg;
    logic [15:0]       init_win_reg;
    logic [WIN_W-1:0]  cwnd_reg;
    logic [WIN_W-1:0]  ssthr_reg;
    logic [CNT_W-1:0]  outst_reg;
    logic              m_tvalid_reg;
    logic [1:0]        send_state_reg;
    logic [WIN_W-1:0]  window_reg;
    logic [CNT_W-1:0]  in_flight_reg;

    unit_cmd_t         ucmd;
    unit_status_t      ustat;
    logic [RES_W-1:0]  opb;

    logic              accept;
    logic [1:0]        func;
    logic              mark;
    logic [WIN_W-1:0]  floor_w;
    logic [WIN_W-1:0]  mul_res;
    logic [1:0]        send_state;
    logic              out_free;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign func     = s_tdata[1:0];
    assign mark     = s_tuser;
    assign floor_w  = {init_win_reg, 16'h0000};
    assign mul_res  = ustat.result[WIN_W-1:0];
    assign out_free = !m_tvalid_reg || m_tready;

    // Commands to the shared unit; operands are latched by the unit on start.
    always_comb
    begin
        ucmd.start = 1'b0;
        ucmd.op    = OP_ADD;
        opb        = ONE_FIXED;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (func == FUNC_TIMEOUT || (func == FUNC_DATA && mark && react_reg))
                    begin
                        ucmd.start = 1'b1;
                        ucmd.op    = OP_MUL;
                        opb        = {{(RES_W-16){1'b0}}, beta_reg};
                    end
                    else if (func == FUNC_DATA && !mark)
                    begin
                        if (cwnd_reg < ssthr_reg)
                        begin
                            ucmd.start = 1'b1;
                            ucmd.op    = OP_ADD;
                        end
                        else if (cwnd_reg != '0)
                        begin
                            ucmd.start = 1'b1;
                            ucmd.op    = OP_DIV;
                        end
                    end
                end
            end
            S_WAIT_DIV:
            begin
                if (ustat.done)
                begin
                    ucmd.start = 1'b1;
                    ucmd.op    = OP_ADD;
                    opb        = ustat.result;
                end
            end
            default:
            begin
                ucmd.start = 1'b0;
            end
        endcase
    end

    aimd_iter_unit u_unit (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (ucmd),
        .opa    (cwnd_reg),
        .opb    (opb),
        .status (ustat)
    );

    always_comb
    begin
        if (cwnd_reg == '0)
            send_state = SEND_RETRY;
        else if ({outst_reg, 16'h0000} >= cwnd_reg)
            send_state = SEND_FULL;
        else
            send_state = SEND_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            beta_reg     <= 16'h8000;
            react_reg    <= 1'b1;
            init_win_reg <= 16'h0001;
            cwnd_reg     <= WIN_W'(65536);
            ssthr_reg    <= WIN_MAX;
            outst_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_DECREASE: beta_reg <= cfg_wdata;
                    CFG_REACT:    react_reg <= cfg_wdata[0];
                    CFG_INIT_WIN:
                    begin
                        init_win_reg <= cfg_wdata;
                        cwnd_reg     <= {cfg_wdata, 16'h0000};
                    end
                    default: ;
                endcase
            end

            // A new result may replace the one leaving in the same cycle.
            if (state_reg == S_OUT && out_free)
                m_tvalid_reg <= 1'b1;
            else if (m_tvalid_reg && m_tready)
                m_tvalid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= S_OUT;
                        if (func == FUNC_INTEREST)
                        begin
                            if (outst_reg != COUNT_MAX)
                                outst_reg <= outst_reg + CNT_W'(1);
                        end
                        else if (func == FUNC_DATA || func == FUNC_TIMEOUT)
                        begin
                            if (outst_reg != '0)
                                outst_reg <= outst_reg - CNT_W'(1);
                        end

                        if (func == FUNC_TIMEOUT || (func == FUNC_DATA && mark && react_reg))
                            state_reg <= S_WAIT_MUL;
                        else if (func == FUNC_DATA && !mark)
                        begin
                            if (cwnd_reg < ssthr_reg)
                                state_reg <= S_WAIT_ADD;
                            else if (cwnd_reg == '0)
                                cwnd_reg <= WIN_MAX;
                            else
                                state_reg <= S_WAIT_DIV;
                        end
                    end
                end
                S_WAIT_DIV:
                begin
                    if (ustat.done)
                        state_reg <= S_WAIT_ADD;
                end
                S_WAIT_ADD:
                begin
                    if (ustat.done)
                    begin
                        cwnd_reg  <= ustat.result[WIN_W] ? WIN_MAX : ustat.result[WIN_W-1:0];
                        state_reg <= S_OUT;
                    end
                end
                S_WAIT_MUL:
                begin
                    if (ustat.done)
                    begin
                        ssthr_reg <= mul_res;
                        cwnd_reg  <= (mul_res < floor_w) ? floor_w : mul_res;
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out_free)
                        state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_OUT && out_free)
        begin
            send_state_reg <= send_state;
            window_reg     <= cwnd_reg;
            in_flight_reg  <= outst_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'b000000, in_flight_reg, window_reg, send_state_reg};

`ifndef SYNTH
    // The shared unit is never left running when a new event is taken.
    assert property (@(posedge clk) disable iff (!rst_n) s_tready |-> !ustat.busy)
        else $error("iterative unit busy while input is ready");

    // A decrease never leaves the window below the initial window.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WAIT_MUL && ustat.done) |=> (cwnd_reg >= floor_w))
        else $error("window below floor after decrease");

    // A result never reports the unused send code.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg |-> (send_state_reg == SEND_RETRY || send_state_reg == SEND_FULL
                          || send_state_reg == SEND_OK))
        else $error("invalid send_state in result");

    // The unit reports completion only in a state that waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        ustat.done |-> (state_reg == S_WAIT_DIV || state_reg == S_WAIT_ADD
                        || state_reg == S_WAIT_MUL))
        else $error("unit completion outside a wait state");
`endif

endmodule
